// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers with a clock and an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked at every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication checked at every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  `ASSERT_AT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== hdl/b64enc_pkg.sv =====
// ----------------------------------------------------------------------------
// b64enc_pkg
// Types, constants and the alphabet lookup shared by the Base64 encoder.
// ----------------------------------------------------------------------------
package b64enc_pkg;

  localparam int unsigned DATA_W          = 8;
  localparam int unsigned CAP_W           = 16;
  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned MAX_CHARS       = 5;
  localparam int unsigned CHAR_IDX_W      = 3;
  localparam int unsigned QUEUE_DEPTH     = 4;

  localparam logic [CAP_W-1:0]  CAP_RESET = 16'hFFFF;
  localparam logic [DATA_W-1:0] PAD_CHAR  = 8'h3D;
  localparam logic [DATA_W-1:0] NUL_CHAR  = 8'h00;

  // Expanded work for one message byte: its characters in order and how many.
  typedef struct packed {
    logic [MAX_CHARS-1:0][DATA_W-1:0] chars;
    logic [CHAR_IDX_W-1:0]            n_chars;
    logic                             last;
  } b64_plan_t;

  // Map a 6-bit value onto the standard Base64 alphabet.
  function automatic logic [DATA_W-1:0] b64_char(input logic [5:0] v);
    logic [DATA_W-1:0] c;
    begin
      if (v < 6'd26) begin
        c = 8'h41 + {2'b00, v};                  // 'A'..'Z'
      end else if (v < 6'd52) begin
        c = 8'h61 + {2'b00, v} - 8'd26;          // 'a'..'z'
      end else if (v < 6'd62) begin
        c = 8'h30 + {2'b00, v} - 8'd52;          // '0'..'9'
      end else if (v == 6'd62) begin
        c = 8'h2B;                               // '+'
      end else begin
        c = 8'h2F;                               // '/'
      end
      return c;
    end
  endfunction

endpackage

// ===== hdl/b64enc_front.sv =====
// ----------------------------------------------------------------------------
// b64enc_front
// Accepts message bytes, tracks the 3-byte group position and expands each
// byte into its list of output characters, including the end-of-message
// flush, padding and terminator.
// ----------------------------------------------------------------------------
module b64enc_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            take,
  input  logic [b64enc_pkg::DATA_W-1:0]   data_byte,
  input  logic                            last_byte,
  output b64enc_pkg::b64_plan_t           plan
);

  typedef enum logic [1:0] {
    PH_0,
    PH_1,
    PH_2
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [3:0] left_r, left_nxt;

  // Character list for the current byte.
  always_comb begin
    plan.chars   = '0;
    plan.n_chars = '0;
    plan.last    = last_byte;
    phase_nxt    = PH_0;
    left_nxt     = '0;
    case (phase_r)
      PH_0: begin
        plan.chars[0] = b64enc_pkg::b64_char(data_byte[7:2]);
        plan.chars[1] = b64enc_pkg::b64_char({data_byte[1:0], 4'b0000});
        plan.chars[2] = b64enc_pkg::PAD_CHAR;
        plan.chars[3] = b64enc_pkg::PAD_CHAR;
        plan.chars[4] = b64enc_pkg::NUL_CHAR;
        plan.n_chars  = last_byte ? 3'd5 : 3'd1;
        phase_nxt     = PH_1;
        left_nxt      = {2'b00, data_byte[1:0]};
      end
      PH_1: begin
        plan.chars[0] = b64enc_pkg::b64_char({left_r[1:0], data_byte[7:4]});
        plan.chars[1] = b64enc_pkg::b64_char({data_byte[3:0], 2'b00});
        plan.chars[2] = b64enc_pkg::PAD_CHAR;
        plan.chars[3] = b64enc_pkg::NUL_CHAR;
        plan.n_chars  = last_byte ? 3'd4 : 3'd1;
        phase_nxt     = PH_2;
        left_nxt      = data_byte[3:0];
      end
      PH_2: begin
        plan.chars[0] = b64enc_pkg::b64_char({left_r, data_byte[7:6]});
        plan.chars[1] = b64enc_pkg::b64_char(data_byte[5:0]);
        plan.chars[2] = b64enc_pkg::NUL_CHAR;
        plan.n_chars  = last_byte ? 3'd3 : 3'd2;
        phase_nxt     = PH_0;
        left_nxt      = '0;
      end
      default: begin
        phase_nxt = PH_0;
        left_nxt  = '0;
      end
    endcase
    // A message end always restarts the group.
    if (last_byte) begin
      phase_nxt = PH_0;
      left_nxt  = '0;
    end
  end

  // Group position advances on every accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_0;
      left_r  <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

// ===== hdl/b64enc_queue.sv =====
// ----------------------------------------------------------------------------
// b64enc_queue
// Short first-in first-out queue of expanded byte plans between the front
// and the back end.
// ----------------------------------------------------------------------------
module b64enc_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  b64enc_pkg::b64_plan_t push_plan,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output b64enc_pkg::b64_plan_t head_plan
);

  localparam int unsigned DEPTH = b64enc_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  b64enc_pkg::b64_plan_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             do_push, do_pop;

  assign full       = (fill_r == CNT_W'(DEPTH));
  assign head_valid = (fill_r != '0);
  assign head_plan  = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Storage slots carry no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_plan;
    end
  end

endmodule

// ===== hdl/b64enc_back.sv =====
// ----------------------------------------------------------------------------
// b64enc_back
// Walks each queued byte plan one character per cycle while the output is not
// stalled, enforces the output capacity, skips the rest of an aborted message
// and drives the output register.
// ----------------------------------------------------------------------------
module b64enc_back #(
  parameter int unsigned COUNT_WIDTH = b64enc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [b64enc_pkg::CAP_W-1:0]      capacity,
  input  logic                              q_valid,
  input  b64enc_pkg::b64_plan_t             q_plan,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [b64enc_pkg::DATA_W-1:0]     out_char,
  output logic                              out_eot,
  output logic                              out_ovf
);

  localparam int unsigned CMP_W =
    (COUNT_WIDTH > b64enc_pkg::CAP_W) ? COUNT_WIDTH : b64enc_pkg::CAP_W;

  b64enc_pkg::b64_plan_t                plan_r, plan_nxt;
  logic [b64enc_pkg::CHAR_IDX_W-1:0]    idx_r, idx_nxt;
  logic                                 busy_r, busy_nxt;
  logic                                 drop_r, drop_nxt;
  logic [COUNT_WIDTH-1:0]               count_r, count_nxt;
  logic                                 oval_r, oval_nxt;
  logic [b64enc_pkg::DATA_W-1:0]        ochar_r, ochar_nxt;
  logic                                 oeot_r, oeot_nxt;
  logic                                 oovf_r, oovf_nxt;

  logic can_emit, at_limit, fail, last_char, done;
  logic drop_mid, busy_mid;
  logic [COUNT_WIDTH-1:0] count_mid;

  // Capacity check for the character about to go out.
  assign can_emit  = busy_r && (!oval_r || out_ready);
  assign at_limit  = (CMP_W'(count_r) >= CMP_W'(capacity)) || (&count_r);
  assign fail      = can_emit && at_limit;
  assign last_char = (idx_r == plan_r.n_chars - 1'b1);
  assign done      = can_emit && (at_limit || last_char);
  assign q_pop     = q_valid && (!busy_r || done);

  // State after the current character, then the next plan is taken on top.
  always_comb begin
    drop_mid  = fail ? !plan_r.last : drop_r;
    busy_mid  = done ? 1'b0 : busy_r;
    if (fail || (done && plan_r.last)) begin
      count_mid = '0;
    end else if (can_emit) begin
      count_mid = count_r + 1'b1;
    end else begin
      count_mid = count_r;
    end

    plan_nxt  = plan_r;
    idx_nxt   = (can_emit && !done) ? idx_r + 1'b1 : idx_r;
    busy_nxt  = busy_mid;
    drop_nxt  = drop_mid;
    count_nxt = count_mid;
    if (q_pop) begin
      if (drop_mid) begin
        // Skipped byte: the flagged last byte ends the skipping.
        busy_nxt = 1'b0;
        drop_nxt = !q_plan.last;
      end else begin
        busy_nxt = 1'b1;
        plan_nxt = q_plan;
        idx_nxt  = '0;
      end
    end

    // Output register with back-pressure.
    oval_nxt  = can_emit ? 1'b1 : (out_ready ? 1'b0 : oval_r);
    ochar_nxt = ochar_r;
    oeot_nxt  = oeot_r;
    oovf_nxt  = oovf_r;
    if (fail) begin
      ochar_nxt = b64enc_pkg::NUL_CHAR;
      oeot_nxt  = 1'b1;
      oovf_nxt  = 1'b1;
    end else if (can_emit) begin
      ochar_nxt = plan_r.chars[idx_r];
      oeot_nxt  = plan_r.last && last_char;
      oovf_nxt  = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      drop_r  <= 1'b0;
      count_r <= '0;
      idx_r   <= '0;
      oval_r  <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      drop_r  <= drop_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      oval_r  <= oval_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    plan_r  <= plan_nxt;
    ochar_r <= ochar_nxt;
    oeot_r  <= oeot_nxt;
    oovf_r  <= oovf_nxt;
  end

  assign out_valid = oval_r;
  assign out_char  = ochar_r;
  assign out_eot   = oeot_r;
  assign out_ovf   = oovf_r;

endmodule

// ===== hdl/base64_stream_encoder.sv =====
// Path: an accepted byte's plan is written into the queue slot, then into the
//   back-end plan register; each character then passes the output register.
// Throughput: one character per cycle from the back end unless the output is
//   stalled; a byte expands to 1 to 5 characters (about 1.33 per byte inside
//   a message). The 4-entry queue takes one byte per cycle while not full.
// Reset: synchronous, active low; capacity 65535; only control state clears.
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming Base64 encoder with padding, terminator and a capacity limit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module base64_stream_encoder #(
  parameter int unsigned COUNT_WIDTH = b64enc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration
  input  logic                           cfg_we,
  input  logic [b64enc_pkg::CAP_W-1:0]   cfg_wdata,    // out_capacity
  // Input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [b64enc_pkg::DATA_W-1:0]  in_tdata,     // [7:0] data_byte
  input  logic                           in_tlast,     // last_byte
  // Output stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [b64enc_pkg::DATA_W-1:0]  out_tdata,    // [7:0] char_code
  output logic                           out_tlast,    // end_of_text
  output logic                           out_tuser     // [0] overflow
);

  logic [b64enc_pkg::CAP_W-1:0] cap_r;
  b64enc_pkg::b64_plan_t        front_plan, head_plan;
  logic                         q_full, q_valid, q_pop, in_beat;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= b64enc_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  assign in_tready = !q_full;
  assign in_beat   = in_tvalid && in_tready;

  // Front end: group tracking and character expansion.
  b64enc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_beat),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .plan      (front_plan)
  );

  // Plan queue between front and back.
  b64enc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_beat),
    .push_plan  (front_plan),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_plan  (head_plan)
  );

  // Back end: character walk, capacity and output register.
  b64enc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .capacity  (cap_r),
    .q_valid   (q_valid),
    .q_plan    (head_plan),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_tdata),
    .out_eot   (out_tlast),
    .out_ovf   (out_tuser)
  );

  // An abort beat always closes the message.
  `ASSERT_IMPLIES(a_ovf_ends_msg, clk, rst_n, out_tvalid && out_tuser, out_tlast,
    "overflow beat without end mark")
  // An abort beat carries the zero character.
  `ASSERT_IMPLIES(a_ovf_zero_char, clk, rst_n, out_tvalid && out_tuser,
    out_tdata == b64enc_pkg::NUL_CHAR, "overflow beat with nonzero character")
  // Only an end-marked beat (terminator or abort) may carry the zero character.
  `ASSERT_IMPLIES(a_mid_char_nonzero, clk, rst_n, out_tvalid && !out_tlast,
    out_tdata != b64enc_pkg::NUL_CHAR, "zero character before end of message")

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Base64 stream encoder. A local predictor turns
// each accepted input beat into the characters it should produce, and every
// output beat is checked against the oldest of them. Directed messages cover
// the alphabet edges, padding and capacity overflow. Random messages follow
// under changing idle patterns and an output hold-off.
// ----------------------------------------------------------------------------
module tb;

  typedef logic [b64enc_pkg::DATA_W-1:0] byte_t;
  typedef logic [b64enc_pkg::CAP_W-1:0]  cap_t;

  localparam int unsigned      STALL_LIMIT = 4000;
  localparam int unsigned      CFG_SETTLE  = 32;
  localparam int unsigned      TAIL_CYCLES = 40;
  localparam cap_t             COUNT_MAX   = 16'hFFFF;
  localparam logic [8*64-1:0]  ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // Position of the next byte inside its three-byte group.
  typedef enum logic [1:0] {GRP_FIRST, GRP_SECOND, GRP_THIRD} grp_pos_t;

  // One expected output beat.
  typedef struct packed {
    byte_t code;
    logic  eot;
    logic  ovf;
  } enc_char_t;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                cfg_we     = 1'b0;
  cap_t                cfg_wdata  = '0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  byte_t               in_tdata   = '0;
  logic                in_tlast   = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  byte_t               out_tdata;
  logic                out_tlast;
  logic                out_tuser;

  // Predictor state and the characters still owed by the block.
  grp_pos_t            grp;
  logic [3:0]          carry;
  cap_t                chars_done;
  cap_t                capacity;
  bit                  drop_mode;
  bit                  enc_failed;
  enc_char_t           pending_chars[$];

  int                  tx_idle_pct = 0;
  int                  rx_idle_pct = 0;
  int                  rx_hold     = 0;
  int                  error_count = 0;
  int unsigned         stall_cycles = 0;

  base64_stream_encoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),   // out_capacity
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] data_byte
    .in_tlast   (in_tlast),    // last_byte
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [7:0] char_code
    .out_tlast  (out_tlast),   // end_of_text
    .out_tuser  (out_tuser)    // [0] overflow
  );

  // Clock with a 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("tb: mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic void clear_group();
    grp        = GRP_FIRST;
    carry      = '0;
    chars_done = '0;
  endfunction

  // Queue one character, or the overflow beat once the capacity is used up.
  function automatic void push_char(input byte_t code, input logic eot);
    if (enc_failed) begin
      return;
    end
    if (chars_done >= capacity || chars_done == COUNT_MAX) begin
      pending_chars.push_back('{code: b64enc_pkg::NUL_CHAR, eot: 1'b1, ovf: 1'b1});
      enc_failed = 1'b1;
    end else begin
      pending_chars.push_back('{code: code, eot: eot, ovf: 1'b0});
      chars_done++;
    end
  endfunction

  function automatic void push_sextet(input logic [5:0] v);
    push_char(ALPHABET[8*(63 - int'(v)) +: 8], 1'b0);
  endfunction

  // Work out every character that one accepted byte causes.
  function automatic void encode_byte(input byte_t b, input logic last);
    enc_failed = 1'b0;
    if (drop_mode) begin
      if (last) begin
        drop_mode = 1'b0;
        clear_group();
      end
      return;
    end
    case (grp)
      GRP_FIRST: begin
        push_sextet(b[7:2]);
        carry = {2'b00, b[1:0]};
        grp   = GRP_SECOND;
      end
      GRP_SECOND: begin
        push_sextet({carry[1:0], b[7:4]});
        carry = b[3:0];
        grp   = GRP_THIRD;
      end
      default: begin
        push_sextet({carry, b[7:6]});
        push_sextet(b[5:0]);
        carry = '0;
        grp   = GRP_FIRST;
      end
    endcase
    // Flush the partial character, pad and terminate on the last byte.
    if (last && !enc_failed) begin
      if (grp == GRP_SECOND) begin
        push_sextet({carry[1:0], 4'b0000});
        push_char(b64enc_pkg::PAD_CHAR, 1'b0);
        push_char(b64enc_pkg::PAD_CHAR, 1'b0);
      end else if (grp == GRP_THIRD) begin
        push_sextet({carry, 2'b00});
        push_char(b64enc_pkg::PAD_CHAR, 1'b0);
      end
      push_char(b64enc_pkg::NUL_CHAR, 1'b1);
    end
    if (enc_failed) begin
      drop_mode = !last;
      clear_group();
    end else if (last) begin
      clear_group();
    end
  endfunction

  // ---------------------------------------------------------------- output side

  // Ready pattern: a forced hold-off when asked, random idling otherwise.
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold    <= rx_hold - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each output beat with the oldest expected character.
  always @(posedge clk) begin : check_output
    enc_char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch("unexpected beat", int'(out_tdata), 0);
      end else begin
        want = pending_chars.pop_front();
        if (out_tdata !== want.code) begin
          report_mismatch("char_code", int'(out_tdata), int'(want.code));
        end
        if (out_tlast !== want.eot) begin
          report_mismatch("end_of_text", int'(out_tlast), int'(want.eot));
        end
        if (out_tuser !== want.ovf) begin
          report_mismatch("overflow", int'(out_tuser), int'(want.ovf));
        end
      end
    end
  end

  // End the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- input side

  // Offer one byte after a random gap and wait until it is taken.
  task automatic send_byte(input byte_t b, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    encode_byte(b, last);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(byte_t'($urandom_range(255)), i == len - 1);
    end
  endtask

  // Stop offering and wait until every expected character has arrived.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  // Capacity is only changed while the block is idle.
  task automatic set_capacity(input cap_t cap);
    wait_for_results();
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
    capacity   = cap;
  endtask

  // ---------------------------------------------------------------- tests

  // Alphabet edges and all three padding lengths.
  task automatic test_alphabet_edges();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h83, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // Overflow on the first character, on the terminator, mid message, and
  // the bytes that are dropped after an abort.
  task automatic test_capacity_limits();
    set_capacity(16'd0);
    send_byte(8'h41, 1'b1);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b1);
    set_capacity(16'd5);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b1);
    set_capacity(16'd4);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b1);
    set_capacity(16'd1);
    send_byte(8'h00, 1'b1);
    set_capacity(16'd2);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b1);
    set_capacity(b64enc_pkg::CAP_RESET);
  endtask

  // Hold the output off so the block fills and stalls its input.
  task automatic test_output_hold_off();
    rx_hold = 200;
    repeat (3) send_message(8);
    wait_for_results();
  endtask

  // Random messages with random capacities under one idle pattern.
  task automatic test_random_messages(input int n_items, input int tx_pct,
                                      input int rx_pct);
    int sent;
    int len;
    int pick;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(2) == 0) begin
        pick = $urandom_range(9);
        if (pick == 0) begin
          set_capacity(16'd0);
        end else if (pick == 1) begin
          set_capacity(b64enc_pkg::CAP_RESET);
        end else if (pick < 6) begin
          set_capacity(cap_t'($urandom_range(24)));
        end else begin
          set_capacity(cap_t'($urandom_range(65535, 64)));
        end
      end
      len = ($urandom_range(99) < 85) ? $urandom_range(8, 1) : $urandom_range(40, 9);
      for (int i = 0; i < len; i++) begin
        sent++;
        send_byte(byte_t'($urandom_range(255)), i == len - 1);
      end
    end
  endtask

  task automatic finish_run();
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_chars.size() != 0) begin
      report_mismatch("missing beats", pending_chars.size(), 0);
    end
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    capacity   = b64enc_pkg::CAP_RESET;
    drop_mode  = 1'b0;
    enc_failed = 1'b0;
    clear_group();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 23;
    rx_idle_pct = 63;
    test_alphabet_edges();
    test_capacity_limits();
    test_output_hold_off();
    test_random_messages(40, 23, 63);
    test_random_messages(40, 63, 23);
    test_random_messages(40, 0, 0);
    finish_run();
  end

endmodule
